### hdl/dgsp_pkg.sv
// Shared types and constants for the dense graph shortest path block.
// No dependencies; used by dgsp_cell, dgsp_chain and the top level.
`default_nettype none

package dgsp_pkg;

    localparam int TOK_IDX_BITS = 10;   // covers the largest supported node count
    localparam int DIST_BITS    = 40;
    localparam int CFG_BITS     = 9;
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
    localparam logic [CFG_BITS-1:0] NODE_COUNT_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_SOLVE = 2'd2,
        OP_READ  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        TK_CLEAR,
        TK_SEED,
        TK_RELAX,
        TK_FETCH,
        TK_READ
    } tok_kind_t;

    typedef struct packed {
        logic                    valid;
        tok_kind_t               kind;
        logic [TOK_IDX_BITS-1:0] idx;
        logic [DIST_BITS-1:0]    dval;
        logic                    reach;
        logic                    push;
    } token_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_LD_RD,
        S_LD_CMP,
        S_LD_WR2,
        S_SV_CLR,
        S_SV_SEED,
        S_SV_WAIT,
        S_SV_FETCH,
        S_SV_FWAIT,
        S_SV_ROW,
        S_RD_INJ,
        S_RD_WAIT,
        S_RD_OUT
    } state_t;

endpackage

`default_nettype wire

### hdl/dgsp_cell.sv
// One node cell: holds distance, reached and queued flags for one node.
// Depends on dgsp_pkg (token_t).
`default_nettype none

module dgsp_cell #(
    parameter int CELL_ID = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  dgsp_pkg::token_t     tok_in,
    output dgsp_pkg::token_t     tok_out
);

    logic [dgsp_pkg::DIST_BITS-1:0] dist_reg, dist_next;
    logic reach_reg, reach_next;
    logic queued_reg, queued_next;
    dgsp_pkg::token_t tok_reg, tok_next;
    logic match;

    assign match = tok_in.valid &&
                   (tok_in.idx == dgsp_pkg::TOK_IDX_BITS'(CELL_ID));

    always_comb
    begin
        dist_next   = dist_reg;
        reach_next  = reach_reg;
        queued_next = queued_reg;
        tok_next    = tok_in;
        if (tok_in.valid)
        begin
            case (tok_in.kind)
                dgsp_pkg::TK_CLEAR:
                begin
                    reach_next  = 1'b0;
                    queued_next = 1'b0;
                end
                dgsp_pkg::TK_SEED:
                begin
                    if (match)
                    begin
                        reach_next    = 1'b1;
                        dist_next     = '0;
                        queued_next   = 1'b1;
                        tok_next.push = 1'b1;
                    end
                end
                dgsp_pkg::TK_RELAX:
                begin
                    if (match && (!reach_reg || tok_in.dval < dist_reg))
                    begin
                        dist_next  = tok_in.dval;
                        reach_next = 1'b1;
                        if (!queued_reg)
                        begin
                            queued_next   = 1'b1;
                            tok_next.push = 1'b1;
                        end
                    end
                end
                dgsp_pkg::TK_FETCH:
                begin
                    if (match)
                    begin
                        tok_next.dval  = dist_reg;
                        tok_next.reach = reach_reg;
                        queued_next    = 1'b0;
                    end
                end
                dgsp_pkg::TK_READ:
                begin
                    if (match)
                    begin
                        tok_next.dval  = dist_reg;
                        tok_next.reach = reach_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg  <= 1'b0;
            queued_reg <= 1'b0;
            tok_reg    <= '0;
        end
        else
        begin
            reach_reg  <= reach_next;
            queued_reg <= queued_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

### hdl/dgsp_chain.sv
// Row of node cells; tokens enter at cell 0 and leave after the last cell.
// Depends on dgsp_pkg and dgsp_cell.
`default_nettype none

module dgsp_chain #(
    parameter int NODES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  dgsp_pkg::token_t head_tok,
    output dgsp_pkg::token_t tail_tok
);

    dgsp_pkg::token_t link [0:NODES];

    assign link[0] = head_tok;

    for (genvar g = 0; g < NODES; g++)
    begin : g_cell
        dgsp_cell #(.CELL_ID(g)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (link[g]),
            .tok_out (link[g+1])
        );
    end

    assign tail_tok = link[NODES];

endmodule

`default_nettype wire

### hdl/dense_graph_shortest_path_top.sv
// Top level: weight matrix memory, work queue, control sequencer, cell chain.
// Depends on dgsp_pkg and dgsp_chain.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  input    | in_valid / in_ready    | opcode, node_a, node_b, edge_weight
//  result   | out_valid / out_ready  | node_index, distance, reachable
//  config   | cfg_valid / cfg_ready  | cfg_data (node_count)
//
// After reset the matrix is swept to zero, with in_ready low. Clear takes the
// same sweep. Load reads entry (a,b) and, if it is empty or heavier, writes the
// new weight to (a,b) and then to (b,a). Solve clears and seeds the cells and,
// per queue pop, sends a fetch token down the chain, sweeps the row and drains
// its relax tokens. Read sends a read token down the chain. One item is worked
// at a time; a stalled result holds the block only when the next read reaches
// its output stage. cfg_ready is always high.
`default_nettype none

module dense_graph_shortest_path_top #(
    parameter int NODES       = 256,
    parameter int WEIGHT_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  node_a,
    input  wire logic [7:0]  node_b,
    input  wire logic [31:0] edge_weight,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       node_index,
    output logic [39:0]      distance,
    output logic             reachable,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data
);

    localparam int IDXW  = $clog2(NODES);
    localparam int AW    = 2 * IDXW;
    localparam int DEPTH = NODES * NODES;
    localparam int CNTW  = IDXW + 1;
    localparam int FLTW  = IDXW + 2;
    localparam int DW    = dgsp_pkg::DIST_BITS;

    dgsp_pkg::state_t state_reg, state_next;

    logic [dgsp_pkg::CFG_BITS-1:0] node_count_reg;
    logic [CNTW-1:0] active;

    // weight matrix
    logic [WEIGHT_BITS-1:0] wm [0:DEPTH-1];
    logic [WEIGHT_BITS-1:0] wm_rdata_reg;
    logic [AW-1:0] wm_raddr, wm_waddr;
    logic [WEIGHT_BITS-1:0] wm_wdata;
    logic wm_we;

    // work queue
    logic [IDXW-1:0] q_mem [0:NODES-1];
    logic [IDXW-1:0] q_rdata_reg;
    logic [IDXW-1:0] q_head_reg, q_head_next, q_tail_reg, q_tail_next;
    logic [CNTW-1:0] q_count_reg, q_count_next;
    logic q_push, q_pop;

    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [IDXW-1:0] ld_a_reg, ld_a_next, ld_b_reg, ld_b_next;
    logic [WEIGHT_BITS-1:0] ld_w_reg, ld_w_next;
    logic [IDXW-1:0] src_reg, src_next;
    logic src_ok_reg, src_ok_next;
    logic [IDXW-1:0] x_reg, x_next;
    logic [DW-1:0] base_reg, base_next;
    logic [CNTW-1:0] row_i_reg, row_i_next;
    logic rd_pend_reg, rd_pend_next;
    logic [IDXW-1:0] rd_idx_reg, rd_idx_next;
    logic [FLTW-1:0] inflight_reg, inflight_next;
    logic [7:0] res_node_reg, res_node_next;
    logic [DW-1:0] res_dist_reg, res_dist_next;
    logic res_reach_reg, res_reach_next;
    logic out_valid_reg, out_valid_next;
    logic [7:0] node_index_reg;
    logic [DW-1:0] distance_reg;
    logic reachable_reg;
    logic out_load;

    dgsp_pkg::token_t head_tok, tail_tok;
    logic [DW:0] cand_sum;
    logic [DW-1:0] cand;
    logic a_ok, b_ok;
    logic in_acc;

    assign active = (11'(node_count_reg) < 11'(NODES)) ? CNTW'(node_count_reg)
                                                      : CNTW'(NODES);
    assign a_ok   = 11'(node_a) < 11'(NODES);
    assign b_ok   = 11'(node_b) < 11'(NODES);
    assign in_acc = in_valid && in_ready;

    assign cand_sum = {1'b0, base_reg} + (DW + 1)'(wm_rdata_reg);
    assign cand     = cand_sum[DW] ? dgsp_pkg::DIST_MAX : cand_sum[DW-1:0];

    assign q_push = tail_tok.valid && tail_tok.push;

    dgsp_chain #(.NODES(NODES)) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_tok (head_tok),
        .tail_tok (tail_tok)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        ld_a_next      = ld_a_reg;
        ld_b_next      = ld_b_reg;
        ld_w_next      = ld_w_reg;
        src_next       = src_reg;
        src_ok_next    = src_ok_reg;
        x_next         = x_reg;
        base_next      = base_reg;
        row_i_next     = row_i_reg;
        rd_pend_next   = 1'b0;
        rd_idx_next    = rd_idx_reg;
        res_node_next  = res_node_reg;
        res_dist_next  = res_dist_reg;
        res_reach_next = res_reach_reg;
        q_head_next    = q_head_reg;
        q_tail_next    = q_tail_reg;
        q_pop          = 1'b0;
        out_load       = 1'b0;
        wm_raddr       = '0;
        wm_waddr       = '0;
        wm_wdata       = '0;
        wm_we          = 1'b0;
        head_tok       = '0;

        // relax tokens for the row entry read in the previous cycle
        if (rd_pend_reg && wm_rdata_reg != '0)
        begin
            head_tok.valid = 1'b1;
            head_tok.kind  = dgsp_pkg::TK_RELAX;
            head_tok.idx   = dgsp_pkg::TOK_IDX_BITS'(rd_idx_reg);
            head_tok.dval  = cand;
        end

        case (state_reg)
            dgsp_pkg::S_CLR:
            begin
                wm_we        = 1'b1;
                wm_waddr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {AW{1'b1}})
                    state_next = dgsp_pkg::S_IDLE;
            end
            dgsp_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    ld_a_next     = IDXW'(node_a);
                    ld_b_next     = IDXW'(node_b);
                    ld_w_next     = edge_weight[WEIGHT_BITS-1:0];
                    src_next      = IDXW'(node_a);
                    src_ok_next   = a_ok;
                    res_node_next = node_a;
                    case (opcode)
                        dgsp_pkg::OP_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = dgsp_pkg::S_CLR;
                        end
                        dgsp_pkg::OP_LOAD:
                        begin
                            if (a_ok && b_ok && edge_weight[WEIGHT_BITS-1:0] != '0)
                                state_next = dgsp_pkg::S_LD_RD;
                        end
                        dgsp_pkg::OP_SOLVE:
                            state_next = dgsp_pkg::S_SV_CLR;
                        dgsp_pkg::OP_READ:
                        begin
                            if (a_ok)
                                state_next = dgsp_pkg::S_RD_INJ;
                            else
                            begin
                                res_dist_next  = '0;
                                res_reach_next = 1'b0;
                                state_next     = dgsp_pkg::S_RD_OUT;
                            end
                        end
                        default:
                            state_next = dgsp_pkg::S_IDLE;
                    endcase
                end
            end
            dgsp_pkg::S_LD_RD:
            begin
                wm_raddr   = {ld_a_reg, ld_b_reg};
                state_next = dgsp_pkg::S_LD_CMP;
            end
            dgsp_pkg::S_LD_CMP:
            begin
                if (wm_rdata_reg == '0 || ld_w_reg < wm_rdata_reg)
                begin
                    wm_we      = 1'b1;
                    wm_waddr   = {ld_a_reg, ld_b_reg};
                    wm_wdata   = ld_w_reg;
                    state_next = dgsp_pkg::S_LD_WR2;
                end
                else
                    state_next = dgsp_pkg::S_IDLE;
            end
            dgsp_pkg::S_LD_WR2:
            begin
                wm_we      = 1'b1;
                wm_waddr   = {ld_b_reg, ld_a_reg};
                wm_wdata   = ld_w_reg;
                state_next = dgsp_pkg::S_IDLE;
            end
            dgsp_pkg::S_SV_CLR:
            begin
                head_tok.valid = 1'b1;
                head_tok.kind  = dgsp_pkg::TK_CLEAR;
                q_head_next    = '0;
                q_tail_next    = '0;
                state_next     = src_ok_reg ? dgsp_pkg::S_SV_SEED : dgsp_pkg::S_SV_WAIT;
            end
            dgsp_pkg::S_SV_SEED:
            begin
                head_tok.valid = 1'b1;
                head_tok.kind  = dgsp_pkg::TK_SEED;
                head_tok.idx   = dgsp_pkg::TOK_IDX_BITS'(src_reg);
                state_next     = dgsp_pkg::S_SV_WAIT;
            end
            dgsp_pkg::S_SV_WAIT:
            begin
                // pushes only surface at the chain tail, so drain before popping
                if (inflight_reg == '0 && !rd_pend_reg)
                begin
                    if (q_count_reg == '0)
                        state_next = dgsp_pkg::S_IDLE;
                    else
                    begin
                        q_pop       = 1'b1;
                        q_head_next = q_head_reg + 1'b1;
                        state_next  = dgsp_pkg::S_SV_FETCH;
                    end
                end
            end
            dgsp_pkg::S_SV_FETCH:
            begin
                head_tok.valid = 1'b1;
                head_tok.kind  = dgsp_pkg::TK_FETCH;
                head_tok.idx   = dgsp_pkg::TOK_IDX_BITS'(q_rdata_reg);
                state_next     = dgsp_pkg::S_SV_FWAIT;
            end
            dgsp_pkg::S_SV_FWAIT:
            begin
                if (tail_tok.valid && tail_tok.kind == dgsp_pkg::TK_FETCH)
                begin
                    base_next  = tail_tok.dval;
                    x_next     = IDXW'(tail_tok.idx);
                    row_i_next = '0;
                    state_next = dgsp_pkg::S_SV_ROW;
                end
            end
            dgsp_pkg::S_SV_ROW:
            begin
                if (row_i_reg < active)
                begin
                    wm_raddr     = {x_reg, row_i_reg[IDXW-1:0]};
                    rd_pend_next = 1'b1;
                    rd_idx_next  = row_i_reg[IDXW-1:0];
                    row_i_next   = row_i_reg + 1'b1;
                end
                else
                    state_next = dgsp_pkg::S_SV_WAIT;
            end
            dgsp_pkg::S_RD_INJ:
            begin
                head_tok.valid = 1'b1;
                head_tok.kind  = dgsp_pkg::TK_READ;
                head_tok.idx   = dgsp_pkg::TOK_IDX_BITS'(src_reg);
                state_next     = dgsp_pkg::S_RD_WAIT;
            end
            dgsp_pkg::S_RD_WAIT:
            begin
                if (tail_tok.valid && tail_tok.kind == dgsp_pkg::TK_READ)
                begin
                    res_reach_next = tail_tok.reach;
                    res_dist_next  = tail_tok.reach ? tail_tok.dval : '0;
                    state_next     = dgsp_pkg::S_RD_OUT;
                end
            end
            dgsp_pkg::S_RD_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_load   = 1'b1;
                    state_next = dgsp_pkg::S_IDLE;
                end
            end
            default:
                state_next = dgsp_pkg::S_IDLE;
        endcase

        if (q_push)
            q_tail_next = q_tail_next + 1'b1;
    end

    always_comb
    begin
        q_count_next = q_count_reg;
        if (state_reg == dgsp_pkg::S_SV_CLR)
            q_count_next = '0;
        else if (q_push && !q_pop)
            q_count_next = q_count_reg + 1'b1;
        else if (q_pop && !q_push)
            q_count_next = q_count_reg - 1'b1;

        inflight_next = inflight_reg;
        if (head_tok.valid && !tail_tok.valid)
            inflight_next = inflight_reg + 1'b1;
        else if (!head_tok.valid && tail_tok.valid)
            inflight_next = inflight_reg - 1'b1;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wm_we)
            wm[wm_waddr] <= wm_wdata;
        wm_rdata_reg <= wm[wm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            q_mem[q_tail_reg] <= IDXW'(tail_tok.idx);
        q_rdata_reg <= q_mem[q_head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dgsp_pkg::S_CLR;
            clr_cnt_reg    <= '0;
            node_count_reg <= dgsp_pkg::NODE_COUNT_RESET;
            q_head_reg     <= '0;
            q_tail_reg     <= '0;
            q_count_reg    <= '0;
            inflight_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            if (cfg_valid && cfg_ready)
                node_count_reg <= cfg_data;
            q_head_reg    <= q_head_next;
            q_tail_reg    <= q_tail_next;
            q_count_reg   <= q_count_next;
            inflight_reg  <= inflight_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_a_reg      <= ld_a_next;
        ld_b_reg      <= ld_b_next;
        ld_w_reg      <= ld_w_next;
        src_reg       <= src_next;
        src_ok_reg    <= src_ok_next;
        x_reg         <= x_next;
        base_reg      <= base_next;
        row_i_reg     <= row_i_next;
        rd_idx_reg    <= rd_idx_next;
        res_node_reg  <= res_node_next;
        res_dist_reg  <= res_dist_next;
        res_reach_reg <= res_reach_next;
        if (out_load)
        begin
            node_index_reg <= res_node_reg;
            distance_reg   <= res_dist_reg;
            reachable_reg  <= res_reach_reg;
        end
    end

    assign in_ready   = (state_reg == dgsp_pkg::S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign node_index = node_index_reg;
    assign distance   = distance_reg;
    assign reachable  = reachable_reg;

    // a token leaving the chain must have been counted in
    assert property (@(posedge clk) disable iff (!rst_n)
        tail_tok.valid |-> inflight_reg != '0)
        else $error("chain token count underflow");

    // queued flags keep the queue within one entry per node
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> q_count_reg < CNTW'(NODES))
        else $error("work queue overflow");

    // a popped node was queued, so it must have been reached
    assert property (@(posedge clk) disable iff (!rst_n)
        (tail_tok.valid && tail_tok.kind == dgsp_pkg::TK_FETCH) |-> tail_tok.reach)
        else $error("popped node not reached");

    // row reads only follow the row sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == dgsp_pkg::S_SV_ROW ||
                         state_reg == dgsp_pkg::S_SV_WAIT))
        else $error("row read outside solve");

endmodule

`default_nettype wire
